// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk with arst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- rtl/exptok_pkg.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Payload structs, token kind codes, lexer modes and character classifiers.
// ----------------------------------------------------------------------------
package exptok_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int RES_DEPTH   = 4;
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	typedef logic [OFFSET_BITS-1:0] offset_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       final_char;
	} char_item_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        unterminated;
		logic        last_token;
	} token_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_OP,
		MODE_IDENT,
		MODE_INT,
		MODE_FLOAT,
		MODE_STRING
	} lex_mode_t;

	// token kinds
	localparam logic [4:0] KIND_PLUS     = 5'd0;
	localparam logic [4:0] KIND_MINUS    = 5'd1;
	localparam logic [4:0] KIND_STAR     = 5'd2;
	localparam logic [4:0] KIND_SLASH    = 5'd3;
	localparam logic [4:0] KIND_PERCENT  = 5'd4;
	localparam logic [4:0] KIND_COMMA    = 5'd5;
	localparam logic [4:0] KIND_COLON    = 5'd6;
	localparam logic [4:0] KIND_SEMI     = 5'd7;
	localparam logic [4:0] KIND_AMP      = 5'd8;
	localparam logic [4:0] KIND_LPAREN   = 5'd9;
	localparam logic [4:0] KIND_RPAREN   = 5'd10;
	localparam logic [4:0] KIND_LBRACE   = 5'd11;
	localparam logic [4:0] KIND_RBRACE   = 5'd12;
	localparam logic [4:0] KIND_QUESTION = 5'd13;
	localparam logic [4:0] KIND_BANG     = 5'd14;
	localparam logic [4:0] KIND_ASSIGN   = 5'd16;
	localparam logic [4:0] KIND_GT       = 5'd18;
	localparam logic [4:0] KIND_LT       = 5'd20;
	localparam logic [4:0] KIND_IDENT    = 5'd22;
	localparam logic [4:0] KIND_INT      = 5'd23;
	localparam logic [4:0] KIND_FLOAT    = 5'd24;
	localparam logic [4:0] KIND_STRING   = 5'd25;
	localparam logic [4:0] KIND_END      = 5'd26;

	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_QUOTE = "\"";
	localparam logic [7:0] CH_UNDER = "_";

	typedef struct packed {
		logic       hit;
		logic [4:0] kind;
	} kind_hit_t;

	function automatic kind_hit_t punct_decode(input logic [7:0] c);
		kind_hit_t r;
		r.hit = 1'b1;
		case (c)
			"+": r.kind = KIND_PLUS;
			"-": r.kind = KIND_MINUS;
			"*": r.kind = KIND_STAR;
			"/": r.kind = KIND_SLASH;
			"%": r.kind = KIND_PERCENT;
			",": r.kind = KIND_COMMA;
			":": r.kind = KIND_COLON;
			";": r.kind = KIND_SEMI;
			"&": r.kind = KIND_AMP;
			"(": r.kind = KIND_LPAREN;
			")": r.kind = KIND_RPAREN;
			"{": r.kind = KIND_LBRACE;
			"}": r.kind = KIND_RBRACE;
			"?": r.kind = KIND_QUESTION;
			default: begin
				r.hit  = 1'b0;
				r.kind = KIND_PLUS;
			end
		endcase
		return r;
	endfunction

	// Bytes that may open a two-character operator.
	function automatic kind_hit_t op_decode(input logic [7:0] c);
		kind_hit_t r;
		r.hit = 1'b1;
		case (c)
			"!":   r.kind = KIND_BANG;
			CH_EQ: r.kind = KIND_ASSIGN;
			">":   r.kind = KIND_GT;
			"<":   r.kind = KIND_LT;
			default: begin
				r.hit  = 1'b0;
				r.kind = KIND_BANG;
			end
		endcase
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	function automatic logic is_decimal(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic token_t make_token(input logic [4:0] kind, input offset_t start,
		input offset_t len, input logic unterm, input logic last);
		token_t t;
		t.token_kind   = kind;
		t.token_start  = 16'(start);
		t.token_length = 16'(len);
		t.unterminated = unterm;
		t.last_token   = last;
		return t;
	endfunction

endpackage

// ----- rtl/expression_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer unit
// A byte accepted into the input register has its tokens written to the
// token buffer once the buffer is free; tok_valid comes from that buffer.
// Throughput: one byte per cycle while each byte yields at most one token and the
// receiver takes it; a byte that yields more (up to four) holds the input until
// the single output port has drained the token buffer, one token per ready cycle.
// Reset: arst_n clears the lexer state, the input stage and the token buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module expression_tokenizer_unit import exptok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  char_item_t char_item,
	output logic       tok_valid,
	input  logic       tok_ready,
	output token_t     tok_item
);

	// input stage
	logic       valid_s1;
	char_item_t item_s1;

	// lexer state
	lex_mode_t  mode_q;
	offset_t    pos_q;
	offset_t    pstart_q;
	logic [4:0] pop_q;

	// token buffer: entry 0 is the head, shifted down on each pop
	token_t                 buf_q [RES_DEPTH];
	logic [RES_CNT_W-1:0]   rem_q;

	// per-byte results
	token_t                 res [RES_DEPTH];
	logic [RES_CNT_W-1:0]   n;
	lex_mode_t              mode_n;
	offset_t                pstart_n;
	logic [4:0]             pop_n;
	logic                   consumed;
	logic [7:0]             c;
	offset_t                next_pos;
	kind_hit_t              punct;
	kind_hit_t              opk;

	logic tok_pop;
	logic buf_free;
	logic advance;

	assign tok_valid = (rem_q != '0);
	assign tok_item  = buf_q[0];
	assign tok_pop   = tok_valid && tok_ready;

	// The buffer can take the next byte's tokens once its last entry leaves.
	assign buf_free   = (rem_q == '0) || (rem_q == RES_CNT_W'(1) && tok_ready);
	assign advance    = valid_s1 && buf_free;
	assign char_ready = !valid_s1 || buf_free;

	assign c        = item_s1.char_code;
	assign next_pos = pos_q + offset_t'(1);
	assign punct    = punct_decode(c);
	assign opk      = op_decode(c);

	// Lex one byte: close the pending token, start a new one, then flush on
	// the final byte and append the two end tokens.
	always_comb begin
		for (int i = 0; i < RES_DEPTH; i++) begin
			res[i] = make_token(KIND_END, '0, '0, 1'b0, 1'b0);
		end
		n        = '0;
		mode_n   = mode_q;
		pstart_n = pstart_q;
		pop_n    = pop_q;
		consumed = 1'b0;

		case (mode_q)
			MODE_STRING: begin
				consumed = 1'b1;
				if (c == CH_QUOTE) begin
					res[n[1:0]] = make_token(KIND_STRING, pstart_q, pos_q - pstart_q,
						1'b0, 1'b0);
					n      = n + RES_CNT_W'(1);
					mode_n = MODE_IDLE;
				end
			end
			MODE_OP: begin
				if (c == CH_EQ) begin
					// two-character form: consume the '='
					res[n[1:0]] = make_token(pop_q + 5'd1, pstart_q, offset_t'(2),
						1'b0, 1'b0);
					consumed = 1'b1;
				end else begin
					res[n[1:0]] = make_token(pop_q, pstart_q, offset_t'(1), 1'b0, 1'b0);
				end
				n      = n + RES_CNT_W'(1);
				mode_n = MODE_IDLE;
			end
			MODE_IDENT: begin
				if (is_letter(c)) begin
					consumed = 1'b1;
				end else begin
					res[n[1:0]] = make_token(KIND_IDENT, pstart_q, pos_q - pstart_q,
						1'b0, 1'b0);
					n      = n + RES_CNT_W'(1);
					mode_n = MODE_IDLE;
				end
			end
			MODE_INT: begin
				if (is_decimal(c)) begin
					consumed = 1'b1;
				end else if (c == CH_DOT) begin
					consumed = 1'b1;
					mode_n   = MODE_FLOAT;
				end else begin
					res[n[1:0]] = make_token(KIND_INT, pstart_q, pos_q - pstart_q,
						1'b0, 1'b0);
					n      = n + RES_CNT_W'(1);
					mode_n = MODE_IDLE;
				end
			end
			MODE_FLOAT: begin
				if (is_decimal(c)) begin
					consumed = 1'b1;
				end else begin
					res[n[1:0]] = make_token(KIND_FLOAT, pstart_q, pos_q - pstart_q,
						1'b0, 1'b0);
					n      = n + RES_CNT_W'(1);
					mode_n = MODE_IDLE;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		// Start a new token; spaces and unknown bytes fall through.
		if (!consumed) begin
			if (punct.hit) begin
				res[n[1:0]] = make_token(punct.kind, pos_q, offset_t'(1), 1'b0, 1'b0);
				n = n + RES_CNT_W'(1);
			end else if (opk.hit) begin
				mode_n   = MODE_OP;
				pop_n    = opk.kind;
				pstart_n = pos_q;
			end else if (is_letter(c)) begin
				mode_n   = MODE_IDENT;
				pstart_n = pos_q;
			end else if (is_decimal(c)) begin
				mode_n   = MODE_INT;
				pstart_n = pos_q;
			end else if (c == CH_QUOTE) begin
				// string text starts after the opening quote
				mode_n   = MODE_STRING;
				pstart_n = next_pos;
			end
		end

		if (item_s1.final_char) begin
			case (mode_n)
				MODE_OP: begin
					res[n[1:0]] = make_token(pop_n, pstart_n, offset_t'(1), 1'b0, 1'b0);
					n = n + RES_CNT_W'(1);
				end
				MODE_IDENT: begin
					res[n[1:0]] = make_token(KIND_IDENT, pstart_n, next_pos - pstart_n,
						1'b0, 1'b0);
					n = n + RES_CNT_W'(1);
				end
				MODE_INT: begin
					res[n[1:0]] = make_token(KIND_INT, pstart_n, next_pos - pstart_n,
						1'b0, 1'b0);
					n = n + RES_CNT_W'(1);
				end
				MODE_FLOAT: begin
					res[n[1:0]] = make_token(KIND_FLOAT, pstart_n, next_pos - pstart_n,
						1'b0, 1'b0);
					n = n + RES_CNT_W'(1);
				end
				MODE_STRING: begin
					// cut off by end of input
					res[n[1:0]] = make_token(KIND_STRING, pstart_n, next_pos - pstart_n,
						1'b1, 1'b0);
					n = n + RES_CNT_W'(1);
				end
				default: begin
				end
			endcase
			res[n[1:0]] = make_token(KIND_END, next_pos, '0, 1'b0, 1'b0);
			n = n + RES_CNT_W'(1);
			res[n[1:0]] = make_token(KIND_END, next_pos, '0, 1'b0, 1'b1);
			n = n + RES_CNT_W'(1);
		end
	end

	// Control: input stage valid, lexer state, buffer fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_q    <= '0;
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			pop_q    <= '0;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (advance) begin
				rem_q <= n;
				if (item_s1.final_char) begin
					// drop back to the reset state for the next expression
					mode_q   <= MODE_IDLE;
					pos_q    <= '0;
					pstart_q <= '0;
					pop_q    <= '0;
				end else begin
					mode_q   <= mode_n;
					pos_q    <= next_pos;
					pstart_q <= pstart_n;
					pop_q    <= pop_n;
				end
			end else if (tok_pop) begin
				rem_q <= rem_q - RES_CNT_W'(1);
			end
		end
	end

	// Payload: input register and token buffer.
	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_item;
		end
		if (advance) begin
			buf_q <= res;
		end else if (tok_pop) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	`ASSERT_NEVER(a_rem_range, rem_q > RES_CNT_W'(RES_DEPTH), "token buffer overflow")
	`ASSERT_CLK(a_last_is_tail, tok_valid && tok_item.last_token |-> rem_q == RES_CNT_W'(1), "last not at tail")
	`ASSERT_CLK(a_last_is_end, tok_valid && tok_item.last_token |-> tok_item.token_kind == KIND_END, "last not end")
	`ASSERT_CLK(a_final_resets, advance && item_s1.final_char |=> pos_q == '0 && mode_q == MODE_IDLE, "no reset")

endmodule

// ----- dv/expression_tokenizer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer unit testbench
// Streams expression bytes into the lexer and checks every emitted token,
// field by field and in order, against a predictor built into the bench.
// The run has three parts. A directed table comes first: its corner rows carry
// hand-written tokens and the rest are predicted. Random expressions follow,
// with idle bursts on both channels, a long receiver hold-off and a drain
// pause. Last, a few random expressions run with no idling on either side.
// ----------------------------------------------------------------------------
module expression_tokenizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import exptok_pkg::*;

	localparam int RANDOM_ITEMS = 110;
	localparam int LAST_EXPRS   = 3;
	localparam int HOLD_CYCLES  = 40;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	// One row of stimulus; typed rows carry their tokens written out by hand.
	typedef struct packed {
		char_item_t   item;
		logic         typed;
		logic [1:0]   n_typed;
		token_t [2:0] toks;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_ready;
	char_item_t char_item;
	logic       tok_valid;
	logic       tok_ready;
	token_t     tok_item;

	// Predictor state: mirrors the lexer's mode, position and pending token.
	lex_mode_t  pmode;
	offset_t    ppos;
	offset_t    pstart;
	logic [4:0] pop;

	token_t     lexed_q[$];     // tokens produced by the latest byte
	token_t     tokens_due[$];  // tokens still to come out of the unit
	dir_row_t   dir_rows[$];
	logic [7:0] expr_q[$];

	string      punct_chars = "+-*/%,:;&(){}?";
	string      op_chars    = "!=><";
	string      dir_expr    = "_Zz9.1.==<=>!&\"s\"!=>";

	bit         failed;
	bit         idling;
	bit         hold_req;
	int         rx_stall;
	int         quiet_cycles;
	int         sent_random;
	int         expr_idx;

	expression_tokenizer_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_item   (tok_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Character classes and token building
	// ------------------------------------------------------------------

	// Position of c in s, or -1 when absent.
	function automatic int find_in(input string s, input logic [7:0] c);
		for (int i = 0; i < s.len(); i++)
			if (s[i] == c)
				return i;
		return -1;
	endfunction

	// Fold case with bit 5, then check the lower-case range.
	function automatic logic alpha_byte(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		return (lc >= "a" && lc <= "z") || c == CH_UNDER;
	endfunction

	function automatic logic digit_byte(input logic [7:0] c);
		return c[7:4] == 4'h3 && c[3:0] <= 4'd9;
	endfunction

	function automatic token_t tok_of(input logic [4:0] kind, input logic [15:0] start,
		input logic [15:0] len, input logic unt, input logic last);
		token_t t;
		t.token_kind   = kind;
		t.token_start  = start;
		t.token_length = len;
		t.unterminated = unt;
		t.last_token   = last;
		return t;
	endfunction

	function automatic dir_row_t row_of(input logic [7:0] ch, input logic fin,
		input logic [1:0] n, input token_t t0, input token_t t1, input token_t t2);
		dir_row_t r;
		r.item.char_code  = ch;
		r.item.final_char = fin;
		r.typed           = (n != 2'd0);
		r.n_typed         = n;
		r.toks            = {t2, t1, t0};
		return r;
	endfunction

	function automatic void push_lexed(input logic [4:0] kind, input offset_t start,
		input offset_t len, input logic unt, input logic last);
		lexed_q.push_back(tok_of(kind, 16'(start), 16'(len), unt, last));
	endfunction

	// ------------------------------------------------------------------
	// Predictor: advance the lexer by one byte and collect its tokens
	// ------------------------------------------------------------------
	function automatic void lex_byte(input char_item_t it);
		logic [7:0] c;
		offset_t    nxt;
		logic       taken;
		int         pk;
		int         ok;
		c     = it.char_code;
		nxt   = ppos + offset_t'(1);
		taken = 1'b0;
		pk    = find_in(punct_chars, c);
		ok    = find_in(op_chars, c);

		// Let the pending token either swallow the byte or close.
		case (pmode)
			MODE_STRING: begin
				taken = 1'b1;
				if (c == CH_QUOTE) begin
					push_lexed(KIND_STRING, pstart, ppos - pstart, 1'b0, 1'b0);
					pmode = MODE_IDLE;
				end
			end
			MODE_OP: begin
				// '=' turns the pending operator into its two-character form.
				if (c == CH_EQ) begin
					push_lexed(pop + 5'd1, pstart, offset_t'(2), 1'b0, 1'b0);
					taken = 1'b1;
				end else begin
					push_lexed(pop, pstart, offset_t'(1), 1'b0, 1'b0);
				end
				pmode = MODE_IDLE;
			end
			MODE_IDENT: begin
				if (alpha_byte(c)) begin
					taken = 1'b1;
				end else begin
					push_lexed(KIND_IDENT, pstart, ppos - pstart, 1'b0, 1'b0);
					pmode = MODE_IDLE;
				end
			end
			MODE_INT: begin
				if (digit_byte(c)) begin
					taken = 1'b1;
				end else if (c == CH_DOT) begin
					taken = 1'b1;
					pmode = MODE_FLOAT;
				end else begin
					push_lexed(KIND_INT, pstart, ppos - pstart, 1'b0, 1'b0);
					pmode = MODE_IDLE;
				end
			end
			MODE_FLOAT: begin
				if (digit_byte(c)) begin
					taken = 1'b1;
				end else begin
					push_lexed(KIND_FLOAT, pstart, ppos - pstart, 1'b0, 1'b0);
					pmode = MODE_IDLE;
				end
			end
			default: begin
				pmode = MODE_IDLE;
			end
		endcase

		// A byte not swallowed may start something new; spaces and
		// unknown bytes simply drop out here.
		if (!taken) begin
			if (pk >= 0) begin
				push_lexed(KIND_PLUS + 5'(pk), ppos, offset_t'(1), 1'b0, 1'b0);
			end else if (ok >= 0) begin
				pmode  = MODE_OP;
				pop    = KIND_BANG + 5'(2 * ok);
				pstart = ppos;
			end else if (alpha_byte(c)) begin
				pmode  = MODE_IDENT;
				pstart = ppos;
			end else if (digit_byte(c)) begin
				pmode  = MODE_INT;
				pstart = ppos;
			end else if (c == CH_QUOTE) begin
				pmode  = MODE_STRING;
				pstart = nxt;
			end
		end

		// Last byte: flush whatever is pending, close with two end tokens
		// and start the next expression from a clean state.
		if (it.final_char) begin
			case (pmode)
				MODE_OP:     push_lexed(pop, pstart, offset_t'(1), 1'b0, 1'b0);
				MODE_IDENT:  push_lexed(KIND_IDENT, pstart, nxt - pstart, 1'b0, 1'b0);
				MODE_INT:    push_lexed(KIND_INT, pstart, nxt - pstart, 1'b0, 1'b0);
				MODE_FLOAT:  push_lexed(KIND_FLOAT, pstart, nxt - pstart, 1'b0, 1'b0);
				MODE_STRING: push_lexed(KIND_STRING, pstart, nxt - pstart, 1'b1, 1'b0);
				default: ;
			endcase
			push_lexed(KIND_END, nxt, '0, 1'b0, 1'b0);
			push_lexed(KIND_END, nxt, '0, 1'b0, 1'b1);
			pmode  = MODE_IDLE;
			ppos   = '0;
			pstart = '0;
			pop    = '0;
		end else begin
			ppos = nxt;
		end
	endfunction

	// ------------------------------------------------------------------
	// Random expression content
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_alpha();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// Build one expression out of token-shaped pieces with random content.
	// Now and then cut it short so the final byte lands mid-token.
	task automatic build_expr(input bit punct_burst);
		int         pieces;
		int         n;
		logic [7:0] c;
		expr_q.delete();
		if (punct_burst) begin
			// Dense single-byte tokens: fills the token buffer fast.
			repeat (12)
				expr_q.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
			return;
		end
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 5);
					repeat (n) expr_q.push_back(rand_alpha());
				end
				2: begin
					n = $urandom_range(1, 4);
					repeat (n) expr_q.push_back(rand_digit());
				end
				3: begin
					n = $urandom_range(1, 3);
					repeat (n) expr_q.push_back(rand_digit());
					expr_q.push_back(CH_DOT);
					n = $urandom_range(0, 3);
					repeat (n) expr_q.push_back(rand_digit());
				end
				4: begin
					expr_q.push_back(CH_QUOTE);
					n = $urandom_range(0, 4);
					repeat (n) begin
						c = 8'($urandom_range(8'h20, 8'h7E));
						expr_q.push_back(c == CH_QUOTE ? 8'("x") : c);
					end
					if ($urandom_range(0, 3) != 0)
						expr_q.push_back(CH_QUOTE);
				end
				5, 6: begin
					expr_q.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
					if ($urandom_range(0, 1) != 0)
						expr_q.push_back(CH_EQ);
				end
				7: begin
					expr_q.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
				end
				8: begin
					expr_q.push_back(($urandom_range(0, 1) != 0) ? 8'(" ") : CH_DOT);
				end
				default: begin
					expr_q.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		if (expr_q.size() > 1 && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, expr_q.size() - 1);
			while (expr_q.size() > n)
				void'(expr_q.pop_back());
		end
	endtask

	// ------------------------------------------------------------------
	// Byte sender: optional idle burst, offer, hold until accepted
	// ------------------------------------------------------------------
	task automatic send_row(input dir_row_t r);
		// Drop valid only when a gap is taken; otherwise keep it high
		// straight into the next transaction.
		if (idling && $urandom_range(0, 4) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= r.item;
		do
			@(posedge clk);
		while (!char_ready);

		// Accepted at this edge: predict, and queue typed or predicted tokens.
		lexed_q.delete();
		lex_byte(r.item);
		if (r.typed) begin
			for (int k = 0; k < r.n_typed; k++)
				tokens_due.push_back(r.toks[k]);
		end else begin
			foreach (lexed_q[k])
				tokens_due.push_back(lexed_q[k]);
		end
	endtask

	task automatic send_expr();
		for (int i = 0; i < expr_q.size(); i++) begin
			send_row(row_of(expr_q[i], i == expr_q.size() - 1, 2'd0, '0, '0, '0));
			if (expr_q[i] != " ")
				sent_random++;
		end
	endtask

	// Stop offering, then hold until every expected token has come out.
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		arst_n      <= 1'b0;
		char_valid  <= 1'b0;
		char_item   <= '0;
		failed      = 1'b0;
		idling      = 1'b1;
		hold_req    = 1'b0;
		sent_random = 0;
		pmode       = MODE_IDLE;
		ppos        = '0;
		pstart      = '0;
		pop         = '0;

		// Corner rows, each a one-byte expression, tokens written out:
		// opening quote as last byte, byte extremes, punctuation at offset 0.
		dir_rows.push_back(row_of(CH_QUOTE, 1'b1, 2'd3,
			tok_of(KIND_STRING, 16'd1, 16'd0, 1'b1, 1'b0),
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b0),
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b1)));
		dir_rows.push_back(row_of(8'hFF, 1'b1, 2'd2,
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b0),
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b1), '0));
		dir_rows.push_back(row_of(8'h00, 1'b1, 2'd2,
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b0),
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b1), '0));
		dir_rows.push_back(row_of("+", 1'b1, 2'd3,
			tok_of(KIND_PLUS, 16'd0, 16'd1, 1'b0, 1'b0),
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b0),
			tok_of(KIND_END, 16'd1, 16'd0, 1'b0, 1'b1)));
		// Predicted rows: identifier running into digits, int to float,
		// dot after a float, the two-character operators ==, <= and !=,
		// single-character operators closed by another byte, a closed string,
		// and an operator as the last byte.
		for (int i = 0; i < dir_expr.len(); i++)
			dir_rows.push_back(row_of(dir_expr[i], i == dir_expr.len() - 1,
				2'd0, '0, '0, '0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_row(dir_rows[i]);

		// Drain fully before the random part starts.
		wait_drained();

		expr_idx = 0;
		while (sent_random < RANDOM_ITEMS) begin
			idling = ($urandom_range(0, 3) != 0);
			if (expr_idx == 2) begin
				// Long receiver hold-off while the sender keeps offering a
				// punctuation burst: the buffer fills and char_ready drops.
				hold_req = 1'b1;
				build_expr(1'b1);
			end else begin
				if (expr_idx == 7)
					wait_drained();
				build_expr(1'b0);
			end
			send_expr();
			expr_idx++;
		end

		// Last part, no idling: a few expressions back to back.
		idling = 1'b0;
		repeat (LAST_EXPRS) begin
			build_expr(1'b0);
			send_expr();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("expression_tokenizer_unit_tb: PASS");
		else
			$display("expression_tokenizer_unit_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Token receiver: random stall bursts, plus the long hold-off
	// ------------------------------------------------------------------
	initial begin
		tok_ready <= 1'b0;
		rx_stall  = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_stall = HOLD_CYCLES;
			end else if (rx_stall == 0 && idling && $urandom_range(0, 3) == 0) begin
				rx_stall = $urandom_range(1, 3);
			end
			if (rx_stall != 0) begin
				rx_stall--;
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Token checker: each transaction against the oldest expected token
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		token_t want;
		if (arst_n && tok_valid && tok_ready) begin
			if (tokens_due.size() == 0) begin
				$error("token with none expected: kind %0d start %0d length %0d",
					tok_item.token_kind, tok_item.token_start, tok_item.token_length);
				failed = 1'b1;
			end else begin
				want = tokens_due.pop_front();
				if (tok_item.token_kind !== want.token_kind) begin
					$error("token_kind: expected %0d, got %0d",
						want.token_kind, tok_item.token_kind);
					failed = 1'b1;
				end
				if (tok_item.token_start !== want.token_start) begin
					$error("token_start: expected %0d, got %0d",
						want.token_start, tok_item.token_start);
					failed = 1'b1;
				end
				if (tok_item.token_length !== want.token_length) begin
					$error("token_length: expected %0d, got %0d",
						want.token_length, tok_item.token_length);
					failed = 1'b1;
				end
				if (tok_item.unterminated !== want.unterminated) begin
					$error("unterminated: expected %0b, got %0b",
						want.unterminated, tok_item.unterminated);
					failed = 1'b1;
				end
				if (tok_item.last_token !== want.last_token) begin
					$error("last_token: expected %0b, got %0b",
						want.last_token, tok_item.last_token);
					failed = 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if neither channel moves for too long
	// ------------------------------------------------------------------
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((char_valid && char_ready) || (tok_valid && tok_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("expression_tokenizer_unit_tb: FAIL");
				$finish;
			end
		end
	end

endmodule

// ----- expression_tokenizer_unit.f -----
+incdir+rtl
rtl/exptok_pkg.sv
rtl/expression_tokenizer_unit.sv
dv/expression_tokenizer_unit_tb.sv
